### hw/rtl/firdf_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Widths, tap count and opcodes shared by the filter core and its checker.
// ----------------------------------------------------------------------------
package firdf_pkg;

   // filter length and derived address width
   localparam int TAPS  = 1024;
   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   // field widths
   localparam int OP_W     = 1;
   localparam int IDX_W    = 10;
   localparam int COEF_W   = 18;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = COEF_W + SAMPLE_W;
   localparam int ACC_W    = PROD_W + TAP_W + 1;

   // Q2.16 * Q1.15 gives Q.31; drop 16 bits to get back to Q1.15
   localparam int FRAC_SHIFT = 16;

   // stream word widths
   localparam int REQ_FIELDS_W = IDX_W + COEF_W + SAMPLE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = SAMPLE_W;

   // opcodes carried on req_tuser
   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_PUSH = 1'b1;

endpackage

### hw/rtl/fir_filter_direct_form_core.sv
// ----------------------------------------------------------------------------
// Direct-form FIR filter core
// Loadable coefficient store and circular sample delay line; one shared
// multiply-accumulate walks all taps for every pushed sample, then the sum
// is rounded half up and saturated to Q1.15.
// ----------------------------------------------------------------------------
//
//   channel | direction | word contents (lowest bit first)
//   --------+-----------+-----------------------------------------------------
//   req_    | in        | tdata: coef_index[9:0], coef_value[27:10],
//           |           |        sample[43:28], zero pad; tuser: opcode
//   rsp_    | out       | tdata: filtered_sample[15:0]; one word per push
//
// A load writes its coefficient as it is taken. A push walks every tap; the single
// multiplier and the one read port of each memory handle one tap a cycle.
// After reset a clearing pass zeroes both memories; req_tready
// stays low during it. A finished word waits in the output register while
// new loads are taken; the next push result holds until that word leaves.
//
module fir_filter_direct_form_core (
   input  logic                              clock,
   input  logic                              reset,
   // coef_index[9:0], coef_value[27:10], sample[43:28], zeros above
   input  logic [firdf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode[0]
   input  logic [firdf_pkg::OP_W-1:0]        req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // filtered_sample[15:0]
   output logic [firdf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   localparam int TAP_W = firdf_pkg::TAP_W;
   localparam int ACC_W = firdf_pkg::ACC_W;
   localparam int Q_W   = ACC_W - firdf_pkg::FRAC_SHIFT;

   localparam logic [TAP_W-1:0]        LAST_TAP = TAP_W'(firdf_pkg::TAPS - 1);
   localparam logic signed [ACC_W-1:0] RND_HALF =
      ACC_W'(1) << (firdf_pkg::FRAC_SHIFT - 1);
   localparam logic signed [Q_W-1:0]   SAT_MAX  = Q_W'(32767);
   localparam logic signed [Q_W-1:0]   SAT_MIN  = Q_W'(-32768);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_OUT
   } state_type;

   // request fields
   logic [firdf_pkg::IDX_W-1:0]           req_idx;
   logic signed [firdf_pkg::COEF_W-1:0]   req_coef;
   logic signed [firdf_pkg::SAMPLE_W-1:0] req_smp;
   logic                                  req_fire;
   logic                                  idx_in_range;

   assign req_idx  = req_tdata[firdf_pkg::IDX_W-1:0];
   assign req_coef = req_tdata[firdf_pkg::IDX_W +: firdf_pkg::COEF_W];
   assign req_smp  = req_tdata[firdf_pkg::IDX_W + firdf_pkg::COEF_W +: firdf_pkg::SAMPLE_W];
   assign req_fire = req_tvalid && req_tready;
   assign idx_in_range = 32'(req_idx) < 32'(firdf_pkg::TAPS);

   // memories
   logic signed [firdf_pkg::COEF_W-1:0]   coef_mem [firdf_pkg::TAPS];
   logic signed [firdf_pkg::SAMPLE_W-1:0] delay_mem [firdf_pkg::TAPS];

   logic                                  coef_we;
   logic [TAP_W-1:0]                      coef_waddr;
   logic signed [firdf_pkg::COEF_W-1:0]   coef_wdata;
   logic                                  delay_we;
   logic [TAP_W-1:0]                      delay_waddr;
   logic signed [firdf_pkg::SAMPLE_W-1:0] delay_wdata;

   // sequencer and datapath registers
   state_type                             state_ff, state_in;
   logic [TAP_W-1:0]                      tap_cnt_ff, tap_cnt_in;
   logic [TAP_W-1:0]                      wr_ptr_ff, wr_ptr_in;
   logic [TAP_W-1:0]                      rd_ptr_ff, rd_ptr_in;
   logic                                  rd_vld_ff, rd_vld_in;
   logic                                  mul_vld_ff, mul_vld_in;
   logic signed [firdf_pkg::COEF_W-1:0]   coef_rd_ff;
   logic signed [firdf_pkg::SAMPLE_W-1:0] smp_rd_ff;
   logic signed [firdf_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]               acc_ff, acc_in;
   logic                                  rsp_vld_ff, rsp_vld_in;
   logic [firdf_pkg::RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   // rounding and saturation
   logic signed [ACC_W-1:0]               rnd_sum;
   logic signed [Q_W-1:0]                 rnd_q;
   logic [firdf_pkg::RSP_DATA_W-1:0]      sat_out;

   assign rnd_sum = acc_ff + RND_HALF;
   assign rnd_q   = $signed(rnd_sum[ACC_W-1:firdf_pkg::FRAC_SHIFT]);

   always_comb begin
      if (rnd_q > SAT_MAX) begin
         sat_out = SAT_MAX[firdf_pkg::RSP_DATA_W-1:0];
      end else if (rnd_q < SAT_MIN) begin
         sat_out = SAT_MIN[firdf_pkg::RSP_DATA_W-1:0];
      end else begin
         sat_out = rnd_q[firdf_pkg::RSP_DATA_W-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      tap_cnt_in  = tap_cnt_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_vld_in   = 1'b0;
      mul_vld_in  = rd_vld_ff;
      prod_in     = coef_rd_ff * smp_rd_ff;
      acc_in      = acc_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      coef_we     = 1'b0;
      coef_waddr  = TAP_W'(req_idx);
      coef_wdata  = req_coef;
      delay_we    = 1'b0;
      delay_waddr = wr_ptr_ff;
      delay_wdata = req_smp;

      if (mul_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      case (state_ff)
         S_CLEAR: begin
            coef_we     = 1'b1;
            coef_waddr  = tap_cnt_ff;
            coef_wdata  = '0;
            delay_we    = 1'b1;
            delay_waddr = tap_cnt_ff;
            delay_wdata = '0;
            tap_cnt_in  = tap_cnt_ff + 1'b1;
            if (tap_cnt_ff == LAST_TAP) begin
               tap_cnt_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == firdf_pkg::OP_LOAD) begin
                  coef_we = idx_in_range;
               end else begin
                  // store the new sample, then walk back from it
                  delay_we   = 1'b1;
                  rd_ptr_in  = wr_ptr_ff;
                  wr_ptr_in  = (wr_ptr_ff == LAST_TAP) ? '0 : wr_ptr_ff + 1'b1;
                  tap_cnt_in = '0;
                  acc_in     = '0;
                  state_in   = S_MAC;
               end
            end
         end
         S_MAC: begin
            rd_vld_in  = 1'b1;
            tap_cnt_in = tap_cnt_ff + 1'b1;
            rd_ptr_in  = (rd_ptr_ff == '0) ? LAST_TAP : rd_ptr_ff - 1'b1;
            if (tap_cnt_ff == LAST_TAP) begin
               tap_cnt_in = '0;
               state_in   = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait for the last product to land in the accumulator
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = sat_out;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         tap_cnt_ff <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tap_cnt_ff <= tap_cnt_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[tap_cnt_ff];
   end

   // sample delay line
   always_ff @(posedge clock) begin
      if (delay_we) begin
         delay_mem[delay_waddr] <= delay_wdata;
      end
      smp_rd_ff <= delay_mem[rd_ptr_ff];
   end

endmodule

### hw/rtl/firdf_checker.sv
// ----------------------------------------------------------------------------
// FIR filter port checker
// Watches the stream ports of the filter core over time.
// ----------------------------------------------------------------------------
module firdf_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [firdf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [firdf_pkg::OP_W-1:0]        req_tuser,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [firdf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // a waiting request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request word changed or dropped while waiting");

   // the clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("input taken during clearing pass");

   // a push occupies the accumulator and holds off further input
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == firdf_pkg::OP_PUSH
      |=> !req_tready ##1 !req_tready)
      else $error("input taken while a push is in progress");

   // a coefficient load never produces a word
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == firdf_pkg::OP_LOAD && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result word without a push");

endmodule

bind fir_filter_direct_form_core firdf_checker u_firdf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR filter core testbench
// Loads coefficients and pushes samples over the request stream, predicts
// each filtered output with a tap-by-tap sum in the bench, and compares every
// result word in order. Covers start-up history, half-up rounding, both
// saturation limits, ignored fields, a long output stall and random traffic.
// ----------------------------------------------------------------------------
module testbench;
   import firdf_pkg::*;

   localparam int LONG_HOLD_CYCLES = 4000;
   localparam int RANDOM_ITEMS     = 550;

   logic                   clock = 1'b0;
   logic                   reset;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;

   // bench copy of the filter state
   logic signed [COEF_W-1:0]   coef_mem [TAPS];
   logic signed [SAMPLE_W-1:0] sample_hist [TAPS];
   logic [TAP_W-1:0]           hist_wptr;

   logic [RSP_DATA_W-1:0] expected_outputs [$];
   int                    fail_count = 0;
   bit                    no_idle = 1'b0;
   bit                    hold_off_request = 1'b0;

   fir_filter_direct_form_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #2 clock = ~clock;

   // Write the sample into history, sum all taps, round half up, saturate.
   function automatic logic [RSP_DATA_W-1:0] filter_push(
      input logic signed [SAMPLE_W-1:0] smp
   );
      longint           acc;
      longint           rounded;
      logic [TAP_W-1:0] tap_pos;
      sample_hist[hist_wptr] = smp;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
         tap_pos = hist_wptr - k[TAP_W-1:0];
         acc += longint'(coef_mem[k]) * longint'(sample_hist[tap_pos]);
      end
      hist_wptr = hist_wptr + 1'b1;
      rounded = (acc + 64'sd32768) >>> FRAC_SHIFT;
      if (rounded > 32767)
         rounded = 32767;
      if (rounded < -32768)
         rounded = -32768;
      return rounded[RSP_DATA_W-1:0];
   endfunction

   // Offer one request word and update the bench state once it is taken.
   task automatic send_word(input logic [OP_W-1:0] op, input int idx, input int coef,
                            input int smp);
      int                    gap;
      logic [REQ_DATA_W-1:0] word;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      word = '0;
      word[IDX_W-1:0] = idx[IDX_W-1:0];
      word[IDX_W +: COEF_W] = coef[COEF_W-1:0];
      word[IDX_W+COEF_W +: SAMPLE_W] = smp[SAMPLE_W-1:0];
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= word;
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         if (idx[IDX_W-1:0] < TAPS)
            coef_mem[idx[IDX_W-1:0]] = coef[COEF_W-1:0];
      end else begin
         expected_outputs.push_back(filter_push(smp[SAMPLE_W-1:0]));
      end
   endtask

   // Result side: random hold-offs per word, plus one long stall on request.
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      logic [RSP_DATA_W-1:0] exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0d",
                     $time, $signed(rsp_tdata));
            fail_count++;
         end else begin
            exp_word = expected_outputs.pop_front();
            if (rsp_tdata !== exp_word) begin
               $display("%0t: filtered_sample mismatch, expected %0d, actual %0d",
                        $time, $signed(exp_word), $signed(rsp_tdata));
               fail_count++;
            end
         end
      end
   end

   // Empty history at first: early outputs only see the newest samples.
   task automatic test_startup_history();
      send_word(OP_PUSH, 0, 0, -32768);
      send_word(OP_LOAD, 0, 65536, 0);
      send_word(OP_LOAD, 2, -32768, 0);
      send_word(OP_LOAD, TAPS - 1, 131071, 0);
      send_word(OP_PUSH, 0, 0, 32767);
      send_word(OP_PUSH, 0, 0, -32768);
      send_word(OP_PUSH, 0, 0, 1000);
   endtask

   // Single active tap so the sum lands exactly on and next to half a step.
   task automatic test_rounding();
      send_word(OP_LOAD, 2, 0, 0);
      send_word(OP_LOAD, TAPS - 1, 0, 0);
      send_word(OP_LOAD, 0, 2, 0);
      send_word(OP_PUSH, 0, 0, 16384);
      send_word(OP_PUSH, 0, 0, -16384);
      send_word(OP_PUSH, 0, 0, -16385);
   endtask

   task automatic test_saturation();
      send_word(OP_LOAD, 0, 131071, 0);
      send_word(OP_PUSH, 0, 0, 32767);
      send_word(OP_LOAD, 0, -131072, 0);
      send_word(OP_PUSH, 0, 0, -32768);
      send_word(OP_PUSH, 0, 0, 32767);
   endtask

   // Coefficient fields on a push and the sample field on a load are don't-care.
   task automatic test_unused_fields();
      send_word(OP_LOAD, 0, 65536, -1);
      send_word(OP_PUSH, TAPS - 1, -1, -5);
      send_word(OP_LOAD, 1, -1, 32767);
      send_word(OP_PUSH, 1, 131071, 12000);
   endtask

   // Stall the result side long enough that the core backs up its input.
   task automatic test_output_stall();
      no_idle = 1'b1;
      hold_off_request = 1'b1;
      for (int i = 0; i < 8; i++)
         send_word(OP_PUSH, $urandom, $urandom, $urandom);
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      int coef;
      int smp;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         // mostly small coefficients so the sum stays off the rails
         case ($urandom_range(0, 9))
            0: coef = $urandom;
            1: coef = 0;
            default: coef = int'($urandom_range(0, 4094)) - 2047;
         endcase
         case ($urandom_range(0, 15))
            0: smp = 32767;
            1: smp = -32768;
            default: smp = $urandom;
         endcase
         if ($urandom_range(0, 9) < 4)
            send_word(OP_PUSH, $urandom, $urandom, smp);
         else
            send_word(OP_LOAD, $urandom_range(0, TAPS - 1), coef, smp);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      coef_mem    = '{default: '0};
      sample_hist = '{default: '0};
      hist_wptr   = '0;
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tuser  <= OP_LOAD;
      req_tvalid <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_startup_history();
      test_rounding();
      test_saturation();
      test_unused_fields();
      test_output_stall();
      test_random_traffic();
      req_tvalid <= 1'b0;

      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (TAPS + 16) @(posedge clock);
      if (expected_outputs.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Generous bound: several times the slowest run with every word a push.
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
hw/rtl/firdf_pkg.sv
hw/rtl/fir_filter_direct_form_core.sv
hw/rtl/firdf_checker.sv
test/testbench.sv
